>>> hw/rtl/tms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tms_pkg;

  // Meaning of the vector carried by one result beat.
  typedef enum logic [1:0] {
    PART_MIN      = 2'd0,
    PART_MAX      = 2'd1,
    PART_CENTROID = 2'd2
  } part_t;

  localparam int THRESH_BITS = 40;
  localparam int SUM63_BITS  = 63;

  // Largest value of a signed 64-bit sum that the area and volume stop at.
  localparam logic [63:0] S63_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

`default_nettype wire

>>> hw/rtl/tms_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module tms_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PB-1:0] wp;
  logic [PB-1:0] rp;
  logic [CB-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != CB'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = mem[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PB'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == PB'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tms_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tms_front #(
  parameter int C = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [9*C-1:0]                     in_vtx,
  input  logic                               in_last,
  output logic                               q_valid,
  input  logic                               q_ready,
  output logic [9*C+6*(C+1):0]               q_data
);

  localparam int IW = 9 * C + 6 * (C + 1) + 1;

  logic signed [C-1:0] vv [9];
  logic [C:0]          du [3];
  logic [C:0]          dw [3];
  logic                hold_v;
  logic [IW-1:0]       hold;
  logic                accept;

  // Edge vectors b-a and c-a are formed here so the back end starts on products.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      vv[i] = in_vtx[i*C +: C];
    end
    for (int i = 0; i < 3; i++) begin
      du[i] = {vv[3+i][C-1], vv[3+i]} - {vv[i][C-1], vv[i]};
      dw[i] = {vv[6+i][C-1], vv[6+i]} - {vv[i][C-1], vv[i]};
    end
  end

  assign in_stall = hold_v && !q_ready;
  assign accept   = in_valid && !in_stall;
  assign q_valid  = hold_v;
  assign q_data   = hold;

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= {in_last, dw[2], dw[1], dw[0], du[2], du[1], du[0], in_vtx};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else begin
      hold_v <= accept || (hold_v && !q_ready);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tms_geom.sv
`timescale 1ns / 1ps
`default_nettype none

module tms_geom #(
  parameter int C = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [9*C+6*(C+1):0]   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [9*C-1:0]         out_vtx,
  output logic [2*C+1:0]         out_root,
  output logic signed [63:0]     out_vol,
  output logic                   out_last
);

  import tms_pkg::*;

  localparam int IW = 9 * C + 6 * (C + 1) + 1;
  localparam int MB = C + 2;
  localparam int PW = 2 * MB;
  localparam int NW = 4 * C + 4;
  localparam int RW = 2 * C + 2;
  localparam int CW = 2 * C + 3;
  localparam int KW = 2 * C + 1;
  localparam int DW = 3 * C + 1;
  localparam int EW = (DW > 64) ? DW + 1 : 65;
  localparam int IB = $clog2(RW);
  localparam logic [4:0] LAST_STEP = 5'd27;

  typedef enum logic [1:0] {G_IDLE, G_MUL, G_ROOT, G_DONE} gstate_t;
  typedef enum logic [2:0] {D_CX, D_CY, D_CZ, D_KX, D_KY, D_KZ, D_N, D_D} dst_t;
  typedef enum logic [1:0] {SH_0, SH_MID, SH_DBL, SH_TOP} sh_t;

  gstate_t          state;
  logic [IW-1:0]    tri_q;
  logic [4:0]       step;
  logic [PW-1:0]    prod;
  logic             p_en;
  logic             p_neg;
  sh_t              p_sh;
  dst_t             p_dst;
  logic signed [CW-1:0] cacc [3];
  logic signed [KW-1:0] kacc [3];
  logic [NW-1:0]    nacc;
  logic signed [DW-1:0] dacc;
  logic [NW-1:0]    rad;
  logic [RW+1:0]    rem;
  logic [RW-1:0]    root;
  logic [IB-1:0]    iter;

  logic [MB-1:0]    mu [3];
  logic [MB-1:0]    mw [3];
  logic             su [3];
  logic             sw [3];
  logic [MB-1:0]    mv [9];
  logic             sv [9];
  logic [CW-1:0]    cm [3];
  logic [KW-1:0]    km [3];
  logic [MB-1:0]    clo [3];
  logic [MB-1:0]    chi [3];
  logic [MB-1:0]    klo [3];
  logic [MB-1:0]    khi [3];
  logic             sk [3];

  logic [MB-1:0]    opa;
  logic [MB-1:0]    opb;
  logic             opneg;
  sh_t              opsh;
  dst_t             opdst;

  logic [NW-1:0]    shifted;
  logic [NW-1:0]    addend;
  logic [RW+3:0]    rem_sh;
  logic [RW+3:0]    trial;

  logic signed [EW-1:0] dx;
  logic signed [EW-1:0] hi_s;
  logic signed [EW-1:0] lo_s;

  // Unpack the queued triangle and take magnitudes and signs of all operands.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      sv[i] = tri_q[i*C + C - 1];
      mv[i] = sv[i] ? MB'(C'(~tri_q[i*C +: C]) + 1'b1) : MB'(tri_q[i*C +: C]);
    end
    for (int i = 0; i < 3; i++) begin
      su[i] = tri_q[9*C + i*(C+1) + C];
      mu[i] = su[i] ? MB'((C+1)'(~tri_q[9*C + i*(C+1) +: C+1]) + 1'b1)
                    : MB'(tri_q[9*C + i*(C+1) +: C+1]);
      sw[i] = tri_q[9*C + (3+i)*(C+1) + C];
      mw[i] = sw[i] ? MB'((C+1)'(~tri_q[9*C + (3+i)*(C+1) +: C+1]) + 1'b1)
                    : MB'(tri_q[9*C + (3+i)*(C+1) +: C+1]);
      cm[i]  = cacc[i][CW-1] ? CW'(~cacc[i] + 1'b1) : CW'(cacc[i]);
      clo[i] = cm[i][MB-1:0];
      chi[i] = MB'(cm[i][2*C+1:MB]);
      sk[i]  = kacc[i][KW-1];
      km[i]  = sk[i] ? KW'(~kacc[i] + 1'b1) : KW'(kacc[i]);
      klo[i] = km[i][MB-1:0];
      khi[i] = MB'(km[i][2*C-1:MB]);
    end
  end

  // Product schedule: cross product, then b x c, then the squares of the
  // cross product (split in halves), then a . (b x c) (split in halves).
  always_comb begin
    opa   = '0;
    opb   = '0;
    opneg = 1'b0;
    opsh  = SH_0;
    opdst = D_CX;
    case (step)
      5'd0: begin opa = mu[1]; opb = mw[2]; opneg = su[1] ^ sw[2]; opdst = D_CX; end
      5'd1: begin opa = mu[2]; opb = mw[1]; opneg = !(su[2] ^ sw[1]); opdst = D_CX; end
      5'd2: begin opa = mu[2]; opb = mw[0]; opneg = su[2] ^ sw[0]; opdst = D_CY; end
      5'd3: begin opa = mu[0]; opb = mw[2]; opneg = !(su[0] ^ sw[2]); opdst = D_CY; end
      5'd4: begin opa = mu[0]; opb = mw[1]; opneg = su[0] ^ sw[1]; opdst = D_CZ; end
      5'd5: begin opa = mu[1]; opb = mw[0]; opneg = !(su[1] ^ sw[0]); opdst = D_CZ; end
      5'd6: begin opa = mv[4]; opb = mv[8]; opneg = sv[4] ^ sv[8]; opdst = D_KX; end
      5'd7: begin opa = mv[5]; opb = mv[7]; opneg = !(sv[5] ^ sv[7]); opdst = D_KX; end
      5'd8: begin opa = mv[5]; opb = mv[6]; opneg = sv[5] ^ sv[6]; opdst = D_KY; end
      5'd9: begin opa = mv[3]; opb = mv[8]; opneg = !(sv[3] ^ sv[8]); opdst = D_KY; end
      5'd10: begin opa = mv[3]; opb = mv[7]; opneg = sv[3] ^ sv[7]; opdst = D_KZ; end
      5'd11: begin opa = mv[4]; opb = mv[6]; opneg = !(sv[4] ^ sv[6]); opdst = D_KZ; end
      5'd12: begin opa = clo[0]; opb = clo[0]; opsh = SH_0;   opdst = D_N; end
      5'd13: begin opa = chi[0]; opb = clo[0]; opsh = SH_DBL; opdst = D_N; end
      5'd14: begin opa = chi[0]; opb = chi[0]; opsh = SH_TOP; opdst = D_N; end
      5'd15: begin opa = clo[1]; opb = clo[1]; opsh = SH_0;   opdst = D_N; end
      5'd16: begin opa = chi[1]; opb = clo[1]; opsh = SH_DBL; opdst = D_N; end
      5'd17: begin opa = chi[1]; opb = chi[1]; opsh = SH_TOP; opdst = D_N; end
      5'd18: begin opa = clo[2]; opb = clo[2]; opsh = SH_0;   opdst = D_N; end
      5'd19: begin opa = chi[2]; opb = clo[2]; opsh = SH_DBL; opdst = D_N; end
      5'd20: begin opa = chi[2]; opb = chi[2]; opsh = SH_TOP; opdst = D_N; end
      5'd21: begin opa = mv[0]; opb = klo[0]; opneg = sv[0] ^ sk[0]; opsh = SH_0;   opdst = D_D; end
      5'd22: begin opa = mv[0]; opb = khi[0]; opneg = sv[0] ^ sk[0]; opsh = SH_MID; opdst = D_D; end
      5'd23: begin opa = mv[1]; opb = klo[1]; opneg = sv[1] ^ sk[1]; opsh = SH_0;   opdst = D_D; end
      5'd24: begin opa = mv[1]; opb = khi[1]; opneg = sv[1] ^ sk[1]; opsh = SH_MID; opdst = D_D; end
      5'd25: begin opa = mv[2]; opb = klo[2]; opneg = sv[2] ^ sk[2]; opsh = SH_0;   opdst = D_D; end
      5'd26: begin opa = mv[2]; opb = khi[2]; opneg = sv[2] ^ sk[2]; opsh = SH_MID; opdst = D_D; end
      default: begin
        opa = '0;
      end
    endcase
  end

  always_comb begin
    case (p_sh)
      SH_0:    shifted = NW'(prod);
      SH_MID:  shifted = NW'(prod) << MB;
      SH_DBL:  shifted = NW'(prod) << (MB + 1);
      SH_TOP:  shifted = NW'(prod) << (2 * MB);
      default: shifted = NW'(prod);
    endcase
    addend = p_neg ? (~shifted + 1'b1) : shifted;
    rem_sh = {rem, rad[NW-1:NW-2]};
    trial  = (RW+4)'({root, 2'b01});
  end

  // Clamp the triple product to +/- S63_MAX, which fits in the signed 64-bit range.
  always_comb begin
    dx   = {{(EW-DW){dacc[DW-1]}}, dacc};
    hi_s = EW'(S63_MAX);
    lo_s = -hi_s;
    if (dx > hi_s) begin
      out_vol = S63_MAX;
    end else if (dx < lo_s) begin
      out_vol = ~S63_MAX + 1'b1;
    end else begin
      out_vol = dx[63:0];
    end
  end

  assign in_ready  = (state == G_IDLE);
  assign out_valid = (state == G_DONE);
  assign out_vtx   = tri_q[9*C-1:0];
  assign out_last  = tri_q[IW-1];
  assign out_root  = root;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      p_en  <= 1'b0;
    end else begin
      case (state)
        G_IDLE: begin
          p_en <= 1'b0;
          if (in_valid) begin
            tri_q <= in_data;
            step  <= '0;
            for (int i = 0; i < 3; i++) begin
              cacc[i] <= '0;
              kacc[i] <= '0;
            end
            nacc  <= '0;
            dacc  <= '0;
            state <= G_MUL;
          end
        end
        G_MUL: begin
          prod  <= opa * opb;
          p_neg <= opneg;
          p_sh  <= opsh;
          p_dst <= opdst;
          p_en  <= (step != LAST_STEP);
          if (step == LAST_STEP) begin
            rad   <= nacc;
            rem   <= '0;
            root  <= '0;
            iter  <= '0;
            state <= G_ROOT;
          end else begin
            step <= step + 1'b1;
          end
        end
        G_ROOT: begin
          p_en <= 1'b0;
          rad  <= rad << 2;
          if (rem_sh >= trial) begin
            rem  <= (RW+2)'(rem_sh - trial);
            root <= {root[RW-2:0], 1'b1};
          end else begin
            rem  <= rem_sh[RW+1:0];
            root <= {root[RW-2:0], 1'b0};
          end
          if (iter == IB'(RW - 1)) begin
            state <= G_DONE;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        G_DONE: begin
          if (out_ready) begin
            state <= G_IDLE;
          end
        end
        default: state <= G_IDLE;
      endcase

      if (p_en) begin
        case (p_dst)
          D_CX: cacc[0] <= cacc[0] + signed'(addend[CW-1:0]);
          D_CY: cacc[1] <= cacc[1] + signed'(addend[CW-1:0]);
          D_CZ: cacc[2] <= cacc[2] + signed'(addend[CW-1:0]);
          D_KX: kacc[0] <= kacc[0] + signed'(addend[KW-1:0]);
          D_KY: kacc[1] <= kacc[1] + signed'(addend[KW-1:0]);
          D_KZ: kacc[2] <= kacc[2] + signed'(addend[KW-1:0]);
          D_N:  nacc    <= nacc + addend;
          D_D:  dacc    <= dacc + signed'(addend[DW-1:0]);
          default: nacc <= nacc;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tms_stats.sv
`timescale 1ns / 1ps
`default_nettype none

module tms_stats #(
  parameter int C  = 16,
  parameter int CB = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           g_valid,
  output logic                           g_ready,
  input  logic [9*C-1:0]                 g_vtx,
  input  logic [2*C+1:0]                 g_root,
  input  logic signed [63:0]             g_vol,
  input  logic                           g_last,
  input  logic [tms_pkg::THRESH_BITS-1:0] thresh,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tms_pkg::part_t                 part,
  output logic signed [C-1:0]            vec_x,
  output logic signed [C-1:0]            vec_y,
  output logic signed [C-1:0]            vec_z,
  output logic [CB-1:0]                  triangle_total,
  output logic [tms_pkg::SUM63_BITS-1:0] surface_area,
  output logic [tms_pkg::SUM63_BITS-1:0] enclosed_volume,
  output logic                           closed,
  output logic                           final_result
);

  import tms_pkg::*;

  localparam int RW = 2 * C + 2;
  localparam int SW = C + CB + 2;
  localparam int DB = $clog2(SW);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_OUT} sstate_t;

  sstate_t              state;
  logic signed [C-1:0]  mn [3];
  logic signed [C-1:0]  mx [3];
  logic [62:0]          area;
  logic signed [63:0]   vsum;
  logic signed [SW-1:0] csum [3];
  logic [CB-1:0]        cnt;

  logic [SW-1:0]        dq [3];
  logic [CB+1:0]        drem [3];
  logic                 dneg [3];
  logic [CB+1:0]        den;
  logic [DB-1:0]        dcnt;

  logic                 ov;
  part_t                opart;
  logic signed [C-1:0]  ovec [3];

  logic signed [C-1:0]  vt [9];
  logic signed [C-1:0]  nmn [3];
  logic signed [C-1:0]  nmx [3];
  logic signed [C+1:0]  ts [3];
  logic signed [SW:0]   cs_w [3];
  logic signed [SW-1:0] ncs [3];
  logic signed [SW:0]   smax;
  logic signed [SW:0]   smin;
  logic [63:0]          asum;
  logic [62:0]          narea;
  logic signed [64:0]   vs_w;
  logic signed [64:0]   vhi;
  logic signed [63:0]   nvsum;
  logic [CB+2:0]        rs [3];
  logic [63:0]          vabs;
  logic [SW-1:0]        nq [3];
  logic [SW-1:0]        cmaxq;
  logic [SW-1:0]        cminq;
  logic signed [C-1:0]  cen [3];
  part_t                lpart;
  logic                 take;
  logic                 outacc;

  assign take   = g_valid && g_ready;
  assign outacc = ov && !out_stall;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      vt[i] = g_vtx[i*C +: C];
    end
    smax = {2'b00, {(SW-1){1'b1}}};
    smin = {2'b11, {(SW-1){1'b0}}};
    for (int a = 0; a < 3; a++) begin
      nmn[a] = mn[a];
      nmx[a] = mx[a];
      for (int k = 0; k < 3; k++) begin
        if (vt[3*k+a] < nmn[a]) nmn[a] = vt[3*k+a];
        if (vt[3*k+a] > nmx[a]) nmx[a] = vt[3*k+a];
      end
      ts[a] = {{2{vt[a][C-1]}}, vt[a]} + {{2{vt[3+a][C-1]}}, vt[3+a]}
            + {{2{vt[6+a][C-1]}}, vt[6+a]};
      cs_w[a] = {csum[a][SW-1], csum[a]} + {{(SW-C-1){ts[a][C+1]}}, ts[a]};
      if (cs_w[a] > smax) begin
        ncs[a] = smax[SW-1:0];
      end else if (cs_w[a] < smin) begin
        ncs[a] = smin[SW-1:0];
      end else begin
        ncs[a] = cs_w[a][SW-1:0];
      end
    end
    asum  = {1'b0, area} + {{(64-RW){1'b0}}, g_root};
    narea = (asum > S63_MAX) ? S63_MAX[62:0] : asum[62:0];
    vs_w  = {vsum[63], vsum} + {g_vol[63], g_vol};
    vhi   = {1'b0, S63_MAX};
    if (vs_w > vhi) begin
      nvsum = S63_MAX;
    end else if (vs_w < -vhi) begin
      nvsum = ~S63_MAX + 1'b1;
    end else begin
      nvsum = vs_w[63:0];
    end
  end

  // Centroid from quotient magnitude and sign, clamped to the coordinate range.
  always_comb begin
    cmaxq = {{(SW-C+1){1'b0}}, {(C-1){1'b1}}};
    cminq = {{(SW-C){1'b0}}, 1'b1, {(C-1){1'b0}}};
    for (int a = 0; a < 3; a++) begin
      rs[a] = {drem[a], dq[a][SW-1]};
      nq[a] = ~dq[a] + 1'b1;
      if (dneg[a]) begin
        cen[a] = (dq[a] > cminq) ? {1'b1, {(C-1){1'b0}}} : nq[a][C-1:0];
      end else begin
        cen[a] = (dq[a] > cmaxq) ? {1'b0, {(C-1){1'b1}}} : dq[a][C-1:0];
      end
    end
    lpart = (state == S_DIV) ? PART_MIN
          : ((opart == PART_MIN) ? PART_MAX : PART_CENTROID);
  end

  always_comb begin
    vabs            = vsum[63] ? (~vsum + 1'b1) : vsum;
    enclosed_volume = vabs[62:0];
    closed          = vabs[62:0] > {{(63-THRESH_BITS){1'b0}}, thresh};
  end

  assign g_ready        = (state == S_IDLE);
  assign out_valid      = ov;
  assign part           = opart;
  assign vec_x          = ovec[0];
  assign vec_y          = ovec[1];
  assign vec_z          = ovec[2];
  assign triangle_total = cnt;
  assign surface_area   = area;
  assign final_result   = (opart == PART_CENTROID);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov    <= 1'b0;
      opart <= PART_MIN;
      for (int a = 0; a < 3; a++) begin
        mn[a]   <= {1'b0, {(C-1){1'b1}}};
        mx[a]   <= {1'b1, {(C-1){1'b0}}};
        csum[a] <= '0;
      end
      area <= '0;
      vsum <= '0;
      cnt  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            for (int a = 0; a < 3; a++) begin
              mn[a]   <= nmn[a];
              mx[a]   <= nmx[a];
              csum[a] <= ncs[a];
            end
            area <= narea;
            vsum <= nvsum;
            if (cnt != {CB{1'b1}}) begin
              cnt <= cnt + 1'b1;
            end
            if (g_last) begin
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          den  <= {2'b00, cnt} + {1'b0, cnt, 1'b0};
          dcnt <= '0;
          for (int a = 0; a < 3; a++) begin
            dneg[a] <= csum[a][SW-1];
            dq[a]   <= csum[a][SW-1] ? SW'(~csum[a] + 1'b1) : SW'(csum[a]);
            drem[a] <= '0;
          end
          state <= S_DIV;
        end
        S_DIV: begin
          for (int a = 0; a < 3; a++) begin
            if (rs[a] >= {1'b0, den}) begin
              drem[a] <= (CB+2)'(rs[a] - {1'b0, den});
              dq[a]   <= {dq[a][SW-2:0], 1'b1};
            end else begin
              drem[a] <= rs[a][CB+1:0];
              dq[a]   <= {dq[a][SW-2:0], 1'b0};
            end
          end
          if (dcnt == DB'(SW - 1)) begin
            ov    <= 1'b1;
            opart <= lpart;
            for (int a = 0; a < 3; a++) begin
              ovec[a] <= mn[a];
            end
            state <= S_OUT;
          end else begin
            dcnt <= dcnt + 1'b1;
          end
        end
        S_OUT: begin
          if (outacc) begin
            if (opart == PART_CENTROID) begin
              ov    <= 1'b0;
              opart <= PART_MIN;
              for (int a = 0; a < 3; a++) begin
                mn[a]   <= {1'b0, {(C-1){1'b1}}};
                mx[a]   <= {1'b1, {(C-1){1'b0}}};
                csum[a] <= '0;
              end
              area  <= '0;
              vsum  <= '0;
              cnt   <= '0;
              state <= S_IDLE;
            end else begin
              opart <= lpart;
              for (int a = 0; a < 3; a++) begin
                ovec[a] <= (lpart == PART_MAX) ? mx[a] : cen[a];
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/triangle_mesh_statistics.sv
// Triangle mesh statistics.
// Input channel (in_valid / in_stall): one beat carries one triangle, nine
// signed coordinates and final_triangle, which marks the last triangle of a
// mesh. A beat is taken at a clock edge where in_valid is high and in_stall low.
// Output channel (out_valid / out_stall): after the last triangle of a mesh the
// block sends three beats in order: min corner, max corner and centroid, each
// with the triangle count, area, absolute volume and the closed flag.
// The config channel (cfg_valid / cfg_ready) writes the 40-bit volume threshold;
// cfg_ready is always high; write it only while the block is idle (not enforced).
// The geometry engine takes a new triangle only after the last one has left;
// each one needs 27 products on one shared multiplier and a root that
// settles one result bit per cycle. A two-entry queue and an input register
// sit ahead of it, so up to three triangles can be absorbed.
// After the last triangle, the engine finishes it and the stats block runs
// the centroid divide before the first result; the three result beats then
// follow back to back unless stalled.
// While out_stall is high the result beat holds, and the input keeps
// filling until the queue is full, then raises in_stall.
// A synchronous reset clears all mesh statistics and sets the threshold to 0.
`timescale 1ns / 1ps
`default_nettype none

module triangle_mesh_statistics #(
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 20
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tms_pkg::THRESH_BITS-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_BITS-1:0]          vertex_a_x,
  input  logic signed [COORD_BITS-1:0]          vertex_a_y,
  input  logic signed [COORD_BITS-1:0]          vertex_a_z,
  input  logic signed [COORD_BITS-1:0]          vertex_b_x,
  input  logic signed [COORD_BITS-1:0]          vertex_b_y,
  input  logic signed [COORD_BITS-1:0]          vertex_b_z,
  input  logic signed [COORD_BITS-1:0]          vertex_c_x,
  input  logic signed [COORD_BITS-1:0]          vertex_c_y,
  input  logic signed [COORD_BITS-1:0]          vertex_c_z,
  input  logic                                  final_triangle,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            part,
  output logic signed [COORD_BITS-1:0]          vec_x,
  output logic signed [COORD_BITS-1:0]          vec_y,
  output logic signed [COORD_BITS-1:0]          vec_z,
  output logic [COUNT_BITS-1:0]                 triangle_total,
  output logic [tms_pkg::SUM63_BITS-1:0]        surface_area,
  output logic [tms_pkg::SUM63_BITS-1:0]        enclosed_volume,
  output logic                                  closed,
  output logic                                  final_result
);

  import tms_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int IW = 9 * C + 6 * (C + 1) + 1;

  logic [THRESH_BITS-1:0] thresh;
  logic [IW-1:0]          f_data;
  logic                   f_valid;
  logic                   f_ready;
  logic [IW-1:0]          q_data;
  logic                   q_valid;
  logic                   q_ready;
  logic                   g_valid;
  logic                   g_ready;
  logic [9*C-1:0]         g_vtx;
  logic [2*C+1:0]         g_root;
  logic signed [63:0]     g_vol;
  logic                   g_last;
  part_t                  s_part;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= '0;
    end else if (cfg_valid && cfg_ready) begin
      thresh <= cfg_data;
    end
  end

  // Front: input register that also forms the edge vectors b-a and c-a.
  tms_front #(.C(C)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_vtx   ({vertex_c_z, vertex_c_y, vertex_c_x,
                vertex_b_z, vertex_b_y, vertex_b_x,
                vertex_a_z, vertex_a_y, vertex_a_x}),
    .in_last  (final_triangle),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_data   (f_data)
  );

  // Queue that lets the front keep taking triangles while the engine works.
  tms_fifo #(.W(IW), .DEPTH(2)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // Geometry engine: area root and clamped triple product per triangle.
  tms_geom #(.C(C)) u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_data   (q_data),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .out_vtx   (g_vtx),
    .out_root  (g_root),
    .out_vol   (g_vol),
    .out_last  (g_last)
  );

  // Mesh accumulators, centroid divide and the three result beats.
  tms_stats #(.C(C), .CB(COUNT_BITS)) u_stats (
    .clk             (clk),
    .rst             (rst),
    .g_valid         (g_valid),
    .g_ready         (g_ready),
    .g_vtx           (g_vtx),
    .g_root          (g_root),
    .g_vol           (g_vol),
    .g_last          (g_last),
    .thresh          (thresh),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .part            (s_part),
    .vec_x           (vec_x),
    .vec_y           (vec_y),
    .vec_z           (vec_z),
    .triangle_total  (triangle_total),
    .surface_area    (surface_area),
    .enclosed_volume (enclosed_volume),
    .closed          (closed),
    .final_result    (final_result)
  );

  assign part = s_part;

  // A mesh always holds at least its last triangle.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (triangle_total != '0))
    else $error("result beat with zero triangle count");

  // Only the centroid beat closes the mesh.
  a_final_is_centroid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (final_result == (s_part == PART_CENTROID)))
    else $error("final_result out of step with part");

  // The three beats of a mesh follow each other without a gap.
  a_beats_contiguous: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !final_result) |=> out_valid)
    else $error("gap inside the result beats of a mesh");

  // A closed mesh has a nonzero volume.
  a_closed_volume: assert property (@(posedge clk) disable iff (rst)
    (out_valid && closed) |-> (enclosed_volume != '0))
    else $error("closed flag with zero volume");

endmodule

`default_nettype wire
